[design/call_graph_arc_counter_assert.svh]
// ----------------------------------------------------------------------------
// Call graph arc counter assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef CALL_GRAPH_ARC_COUNTER_ASSERT_SVH
`define CALL_GRAPH_ARC_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CGAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CGAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cgac_pkg.sv]
// ----------------------------------------------------------------------------
// Call graph arc counter package
// Shared widths, defaults, register indexes and enumerations.
// ----------------------------------------------------------------------------
`default_nettype none

package cgac_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ADDR_BITS_DEF   = 32;

	localparam int IDX_IN_W   = 10;
	localparam int ADDR_IN_W  = 32;
	localparam int COUNT_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int PRIM_W     = 10;

	localparam logic [PRIM_W-1:0] PRIMARY_RESET = 10'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_PC  = 2'd0,
		CFG_HIGH_PC = 2'd1,
		CFG_PRIMARY = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_OUTSIDE = 2'd1,
		KIND_INSIDE  = 2'd2
	} caller_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOW,
		ST_HIGH,
		ST_FILL,
		ST_WALK,
		ST_NEW,
		ST_OUT
	} cgac_state_t;

endpackage

`default_nettype wire

[design/cgac_req_if.sv]
// ----------------------------------------------------------------------------
// Call event channel
// Valid/ready channel that carries one call event per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgac_req_if import cgac_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [IDX_IN_W-1:0]  callee_index;
	logic                 caller_known;
	logic [ADDR_IN_W-1:0] caller_addr;
	logic [ADDR_IN_W-1:0] target_in;

	modport source (output valid, output callee_index, output caller_known,
		output caller_addr, output target_in, input ready);
	modport sink (input valid, input callee_index, input caller_known,
		input caller_addr, input target_in, output ready);

endinterface

`default_nettype wire

[design/cgac_rsp_if.sv]
// ----------------------------------------------------------------------------
// Arc result channel
// Valid/ready channel that carries one arc result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgac_rsp_if import cgac_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [ADDR_IN_W-1:0] target_addr;
	logic [COUNT_W-1:0]   arc_count;
	logic                 table_full;

	modport source (output valid, output target_addr, output arc_count,
		output table_full, input ready);
	modport sink (input valid, input target_addr, input arc_count,
		input table_full, output ready);

endinterface

`default_nettype wire

[design/call_graph_arc_counter.sv]
// ----------------------------------------------------------------------------
// Call graph arc counter
// Counts caller-to-callee arcs in a chained table. One call event enters at a
// time. A callee index beyond the table goes straight to the result; any other
// event reads the head arc, checks the caller against low_pc and high_pc, then
// ends on an unknown caller at a used head, fills an empty head, or walks the
// chain one arc link per step, appending a new arc at its end. The pace is set
// by the single-port arc table, which is read once per arc visited, and by the
// one shared adder that does the range compares and the offset math in turn.
// After reset the table is swept to zero, one entry per cycle, during which no
// call event is taken while configuration writes still land. The result sits in
// its own output register, so the next call event can be taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "call_graph_arc_counter_assert.svh"

module call_graph_arc_counter import cgac_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	cgac_req_if.sink                   req,
	cgac_rsp_if.source                 rsp
);

	// Table index, hop counter and free pointer widths. The free pointer must
	// hold both the table depth and any value of the head-count register.
	localparam int AW    = ADDR_BITS;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int HOP_W = IDX_W + 1;
	localparam int FP_W  = (IDX_W + 1 > PRIM_W) ? IDX_W + 1 : PRIM_W;

	localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(TABLE_DEPTH);
	localparam logic [FP_W-1:0]  FP_LIMIT  = FP_W'(TABLE_DEPTH);

	// One table entry: target and caller offsets relative to low_pc, caller
	// kind, saturating call count and link to the next arc of the chain.
	typedef struct packed {
		logic [AW-1:0]      target;
		logic [AW-1:0]      caller;
		caller_kind_t       kind;
		logic [COUNT_W-1:0] calls;
		logic [IDX_W-1:0]   link;
	} arc_entry_t;

	// Arc table and the registered entry currently being examined.
	arc_entry_t arc_mem_q [TABLE_DEPTH];
	arc_entry_t ent_q;

	// Sequencer and configuration.
	cgac_state_t      state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [AW-1:0]    low_q, high_q;
	logic [FP_W-1:0]  fp_q;

	// Per-transaction working registers.
	logic               known_q;
	logic [AW-1:0]      from_q, to_q;
	logic               oor_q;
	logic               below_q;
	logic [AW-1:0]      rel_q;
	caller_kind_t       kind_q;
	logic [IDX_W-1:0]   cur_q;
	logic [HOP_W-1:0]   hops_q;
	logic [COUNT_W-1:0] count_q;
	logic               full_q;

	// Output register.
	logic                 out_valid_q;
	logic [ADDR_IN_W-1:0] out_target_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_full_q;

	// Memory port controls.
	logic             mem_we, mem_rd;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	arc_entry_t       mem_wd;

	// Shared adder/subtractor.
	logic [AW-1:0] alu_a, alu_b, alu_res;
	logic          alu_sub, alu_borrow;
	logic [AW:0]   alu_sum;

	// Decision terms.
	logic               in_ready, req_accept, idx_oor, out_free, res_load;
	logic               ent_match, ent_unknown, ent_empty, link_zero;
	logic               hop_over, fp_bad, walk_done, walk_step;
	logic               follow, alloc, full_hit, caller_inside;
	logic [COUNT_W-1:0] calls_inc, fill_calls;
	arc_entry_t         fill_ent, walk_ent, new_ent;

	assign req.ready   = in_ready;
	assign req_accept  = req.valid && in_ready;
	assign idx_oor     = 32'(req.callee_index) >= 32'(TABLE_DEPTH);
	assign out_free    = !out_valid_q || rsp.ready;
	assign res_load    = (state_q == ST_OUT) && out_free;

	// A walk stops at an arc with the same caller, or at an arc whose caller
	// is still unknown; such an arc is claimed for this caller.
	assign ent_match   = (ent_q.kind == kind_q) && (ent_q.caller == rel_q);
	assign ent_unknown = ent_q.kind == KIND_UNKNOWN;
	assign ent_empty   = ent_q.target == '0;
	assign link_zero   = ent_q.link == '0;
	assign hop_over    = hops_q >= HOP_LIMIT;
	assign fp_bad      = (fp_q >= FP_LIMIT) || (fp_q == '0);

	assign walk_done = (state_q == ST_WALK) && (ent_match || ent_unknown);
	assign walk_step = (state_q == ST_WALK) && !ent_match && !ent_unknown && !hop_over;
	assign follow    = walk_step && !link_zero;
	assign alloc     = walk_step && link_zero && !fp_bad;
	// No free entry left, or a chain that runs past the table depth: the
	// transaction ends on the current arc with a zero count.
	assign full_hit  = (state_q == ST_WALK) && !ent_match && !ent_unknown &&
		(hop_over || (link_zero && fp_bad));

	assign calls_inc  = (&ent_q.calls) ? ent_q.calls : ent_q.calls + 1'b1;
	assign fill_calls = known_q ? COUNT_W'(1) : ent_q.calls;

	// The shared unit: a - b in the range-check and offset states, a + b when
	// the stored target is turned back into an absolute address.
	assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
		(AW+1)'(alu_sub);
	assign alu_res    = alu_sum[AW-1:0];
	assign alu_borrow = alu_sub && !alu_sum[AW];

	// In the high-side compare the subtractor gives high_pc - caller.
	assign caller_inside = known_q && !below_q && !alu_borrow;

	// Entry images written back to the table.
	always_comb begin
		fill_ent        = ent_q;
		fill_ent.target = alu_res;
		fill_ent.caller = rel_q;
		fill_ent.kind   = kind_q;
		fill_ent.calls  = fill_calls;

		walk_ent = ent_q;
		if (ent_unknown) begin
			walk_ent.caller = rel_q;
			walk_ent.kind   = kind_q;
			walk_ent.calls  = COUNT_W'(1);
		end else if (ent_match) begin
			walk_ent.calls = calls_inc;
		end else begin
			walk_ent.link = IDX_W'(fp_q);
		end

		// A fresh arc inherits the chain's target and starts at one call.
		new_ent.target = ent_q.target;
		new_ent.caller = rel_q;
		new_ent.kind   = kind_q;
		new_ent.calls  = COUNT_W'(1);
		new_ent.link   = '0;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_accept) state_d = idx_oor ? ST_OUT : ST_LOW;
			end
			ST_LOW: begin
				state_d = ST_HIGH;
			end
			ST_HIGH: begin
				if (ent_empty) state_d = ST_FILL;
				else if (!known_q) state_d = ST_OUT;
				else state_d = ST_WALK;
			end
			ST_FILL: begin
				state_d = ST_OUT;
			end
			ST_WALK: begin
				if (walk_done || full_hit) state_d = ST_OUT;
				else if (alloc) state_d = ST_NEW;
			end
			ST_NEW: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: table port and shared adder operands.
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = cur_q;
		mem_wd   = ent_q;
		mem_rd   = 1'b0;
		mem_ra   = cur_q;
		alu_a    = from_q;
		alu_b    = low_q;
		alu_sub  = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_rd   = req_accept;
				mem_ra   = IDX_W'(req.callee_index);
			end
			ST_LOW: begin
				alu_a = from_q;
				alu_b = low_q;
			end
			ST_HIGH: begin
				alu_a = high_q;
				alu_b = from_q;
			end
			ST_FILL: begin
				alu_a  = to_q;
				alu_b  = low_q;
				mem_we = 1'b1;
				mem_wd = fill_ent;
			end
			ST_WALK: begin
				mem_wd = walk_ent;
				mem_we = walk_done || alloc;
				mem_rd = follow;
				mem_ra = ent_q.link;
			end
			ST_NEW: begin
				mem_we = 1'b1;
				mem_wd = new_ent;
			end
			ST_OUT: begin
				alu_a   = ent_q.target;
				alu_b   = low_q;
				alu_sub = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Arc table with a registered read into the working entry. Writes to the
	// current arc also refresh the working copy.
	always_ff @(posedge clk) begin
		if (mem_we) arc_mem_q[mem_wa] <= mem_wd;
		if (mem_rd) ent_q <= arc_mem_q[mem_ra];
		else if (mem_we && (state_q != ST_CLEAR)) ent_q <= mem_wd;
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			low_q       <= '0;
			high_q      <= '0;
			fp_q        <= FP_W'(PRIMARY_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (alloc) fp_q <= fp_q + 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LOW_PC: begin
						low_q <= AW'(cfg_data);
					end
					CFG_HIGH_PC: begin
						high_q <= AW'(cfg_data);
					end
					CFG_PRIMARY: begin
						// A head count of zero still leaves entry zero unused.
						fp_q <= (cfg_data[PRIM_W-1:0] == '0) ? FP_W'(1) :
							FP_W'(cfg_data[PRIM_W-1:0]);
					end
					default: begin
						low_q <= low_q;
					end
				endcase
			end
		end
	end

	// Per-transaction datapath.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			known_q <= req.caller_known;
			from_q  <= AW'(req.caller_addr);
			to_q    <= AW'(req.target_in);
			oor_q   <= idx_oor;
			cur_q   <= IDX_W'(req.callee_index);
			hops_q  <= '0;
			count_q <= '0;
			full_q  <= 1'b0;
		end
		if (state_q == ST_LOW) begin
			below_q <= alu_borrow;
			rel_q   <= alu_res;
		end
		if (state_q == ST_HIGH) begin
			// Unknown and outside callers carry a zero offset.
			if (!caller_inside) rel_q <= '0;
			if (!known_q) kind_q <= KIND_UNKNOWN;
			else if (caller_inside) kind_q <= KIND_INSIDE;
			else kind_q <= KIND_OUTSIDE;
			if (!ent_empty && !known_q) count_q <= ent_q.calls;
		end
		if (state_q == ST_FILL) count_q <= fill_calls;
		if (walk_done) count_q <= ent_unknown ? COUNT_W'(1) : calls_inc;
		if (full_hit) begin
			count_q <= '0;
			full_q  <= 1'b1;
		end
		if (follow) cur_q <= ent_q.link;
		if (alloc) cur_q <= IDX_W'(fp_q);
		if (walk_step) hops_q <= hops_q + 1'b1;
		if (state_q == ST_NEW) count_q <= COUNT_W'(1);
		if (res_load) begin
			out_target_q <= oor_q ? ADDR_IN_W'(to_q) : ADDR_IN_W'(alu_res);
			out_count_q  <= count_q;
			out_full_q   <= full_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.target_addr = out_target_q;
	assign rsp.arc_count   = out_count_q;
	assign rsp.table_full  = out_full_q;

	`CGAC_ASSERT_NEXT(a_accept_leaves_idle, req_accept, state_q != ST_IDLE,
		"accepted call event did not start the sequencer")
	`CGAC_ASSERT_NOW(a_hops_bounded, state_q == ST_WALK, hops_q <= HOP_LIMIT,
		"chain walk ran past the hop limit")
	`CGAC_ASSERT_NEXT(a_fp_step, !cfg_we,
		(fp_q == $past(fp_q)) || (fp_q == $past(fp_q) + 1'b1),
		"free pointer moved by more than one arc")
	`CGAC_ASSERT_NOW(a_full_zero_count, rsp.valid && rsp.table_full,
		rsp.arc_count == '0, "full-table result carries a nonzero count")

endmodule

`default_nettype wire
